>>> design/mwsm_pkg.sv
// Shared types and constants of the mecanum wheel speed mixer.
// Used by every module of the block; depends on nothing else.
package mwsm_pkg;

  localparam int NUM_WHEELS = 4;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  localparam int Q_FRAC  = 20;
  localparam int DEG_X10 = 573;
  localparam logic signed [10:0] DEG_X10_S = 11'sd573;

  localparam int LIN_W  = 16;
  localparam int LEV_W  = 14;
  localparam int TURN_W = 27;
  localparam int LINC_W = 26;
  localparam int NUM_W  = 29;
  localparam int PROD_W = 49;
  localparam int MAG_W  = 28;

  localparam int RECIP_SHIFT = 38;
  localparam int RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_M =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DEG_X10));
  localparam int QUOT_W = MAG_W + RECIP_W - RECIP_SHIFT;

  localparam int RPM_W       = 16;
  localparam int RPM_POS_LIM = 32767;
  localparam int RPM_NEG_LIM = 32768;

  localparam int LIM_W       = 15;
  localparam int DIV_Q_W     = 15;
  localparam int DIV_STEPS   = 3;
  localparam int DIV_STAGES  = DIV_Q_W / DIV_STEPS;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RPM_W-1:0] rpm_t;

  localparam rpm_t RPM_MAX = 16'sh7FFF;
  localparam rpm_t RPM_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPAN_SUM   = 4'd0,
    REG_GIMBAL_X   = 4'd1,
    REG_GIMBAL_Y   = 4'd2,
    REG_SPIN_X     = 4'd3,
    REG_RPM_RATIO  = 4'd4,
    REG_MAX_LINEAR = 4'd5,
    REG_MAX_TURN   = 4'd6,
    REG_MAX_WHEEL  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0]        span_sum_mm;
    logic signed [10:0] gimbal_x_offset_mm;
    logic signed [10:0] gimbal_y_offset_mm;
    logic signed [10:0] spin_x_offset_mm;
    logic [19:0]        rpm_ratio_q20;
    logic [13:0]        max_linear_speed;
    logic [11:0]        max_turn_rate;
    logic [LIM_W-1:0]   wheel_rpm_limit;
  } cfg_t;

endpackage

>>> design/mecanum_wheel_speed_mixer_unit.sv
// Top level of the mecanum wheel speed mixer: configuration registers and the
// three pipeline sections. Depends on mwsm_pkg, mwsm_mix, mwsm_quot, mwsm_scale.
//
// The unit turns a body velocity request (speed_x, speed_y, turn_rate, spin_mode)
// into four wheel speeds in rpm and a flag that marks limit scaling. It is a
// fifteen-stage pipeline, and one request can be accepted in every cycle while
// the output is not stalled. The stage count is set by the chain of three
// multipliers (lever, rpm ratio, reciprocal of 573) and by the limit divider,
// which resolves three quotient bits in each of its five stages. A stalled
// output holds its result while earlier stages keep filling until the pipeline
// is full. Configuration writes are always accepted; index 8 and above are
// ignored. The registers feed the pipeline directly, so write them only while
// no request is in flight.
module mecanum_wheel_speed_mixer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mwsm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mwsm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [14:0]             speed_x_i,
  input  logic signed [14:0]             speed_y_i,
  input  logic signed [12:0]             turn_rate_i,
  input  logic                           spin_mode_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [15:0]             rpm_front_right_o,
  output logic signed [15:0]             rpm_front_left_o,
  output logic signed [15:0]             rpm_back_left_o,
  output logic signed [15:0]             rpm_back_right_o,
  output logic                           was_scaled_o
);
  import mwsm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SPAN_SUM:   cfg_d.span_sum_mm        = cfg_data_i[11:0];
        REG_GIMBAL_X:   cfg_d.gimbal_x_offset_mm = cfg_data_i[10:0];
        REG_GIMBAL_Y:   cfg_d.gimbal_y_offset_mm = cfg_data_i[10:0];
        REG_SPIN_X:     cfg_d.spin_x_offset_mm   = cfg_data_i[10:0];
        REG_RPM_RATIO:  cfg_d.rpm_ratio_q20      = cfg_data_i[19:0];
        REG_MAX_LINEAR: cfg_d.max_linear_speed   = cfg_data_i[13:0];
        REG_MAX_TURN:   cfg_d.max_turn_rate      = cfg_data_i[11:0];
        REG_MAX_WHEEL:  cfg_d.wheel_rpm_limit    = cfg_data_i[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.span_sum_mm        <= 12'd800;
      cfg_q.gimbal_x_offset_mm <= 11'sd0;
      cfg_q.gimbal_y_offset_mm <= 11'sd0;
      cfg_q.spin_x_offset_mm   <= 11'sd0;
      cfg_q.rpm_ratio_q20      <= 20'd6928;
      cfg_q.max_linear_speed   <= 14'd3500;
      cfg_q.max_turn_rate      <= 12'd600;
      cfg_q.wheel_rpm_limit    <= 15'd8500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  logic                        mix_valid, mix_ready;
  prod_t [NUM_WHEELS-1:0]      mix_prod;
  logic                        quot_valid, quot_ready;
  rpm_t [NUM_WHEELS-1:0]       quot_rpm;
  rpm_t [NUM_WHEELS-1:0]       out_rpm;

  mwsm_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .speed_x_i   (speed_x_i),
    .speed_y_i   (speed_y_i),
    .turn_rate_i (turn_rate_i),
    .spin_mode_i (spin_mode_i),
    .out_valid_o (mix_valid),
    .out_ready_i (mix_ready),
    .prod_o      (mix_prod)
  );

  mwsm_quot u_quot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_valid),
    .in_ready_o  (mix_ready),
    .prod_i      (mix_prod),
    .out_valid_o (quot_valid),
    .out_ready_i (quot_ready),
    .rpm_o       (quot_rpm)
  );

  mwsm_scale u_scale (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .wheel_rpm_limit_i (cfg_q.wheel_rpm_limit),
    .in_valid_i        (quot_valid),
    .in_ready_o        (quot_ready),
    .rpm_i             (quot_rpm),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .rpm_o             (out_rpm),
    .scaled_o          (was_scaled_o)
  );

  assign rpm_front_right_o = out_rpm[0];
  assign rpm_front_left_o  = out_rpm[1];
  assign rpm_back_left_o   = out_rpm[2];
  assign rpm_back_right_o  = out_rpm[3];

  // A free output frees every stage behind it, so the input must be ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input not ready although the output is free");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && was_scaled_o) |->
      (rpm_front_right_o != RPM_MIN) && (rpm_front_left_o != RPM_MIN) &&
      (rpm_back_left_o != RPM_MIN) && (rpm_back_right_o != RPM_MIN))
    else $error("scaled wheel speed outside the fifteen-bit quotient range");

  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result presented straight after reset");

endmodule

>>> design/mwsm_mix.sv
// Front of the mixer: command clamping, lever arms and the exact rpm products.
// Four register stages; depends on mwsm_pkg.
module mwsm_mix (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  mwsm_pkg::cfg_t                              cfg_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic signed [14:0]                          speed_x_i,
  input  logic signed [14:0]                          speed_y_i,
  input  logic signed [12:0]                          turn_rate_i,
  input  logic                                        spin_mode_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output mwsm_pkg::prod_t [mwsm_pkg::NUM_WHEELS-1:0]  prod_o
);
  import mwsm_pkg::*;

  localparam int NS = 4;

  function automatic logic signed [14:0] clamp_lin(logic signed [14:0] v, logic [13:0] lim);
    logic signed [15:0] hi, lo, vs;
    hi = $signed({2'b00, lim});
    lo = -hi;
    vs = 16'(v);
    if (vs > hi) return 15'(hi);
    else if (vs < lo) return 15'(lo);
    return v;
  endfunction

  function automatic logic signed [12:0] clamp_turn(logic signed [12:0] v, logic [11:0] lim);
    logic signed [13:0] hi, lo, vs;
    hi = $signed({2'b00, lim});
    lo = -hi;
    vs = 14'(v);
    if (vs > hi) return 13'(hi);
    else if (vs < lo) return 13'(lo);
    return v;
  endfunction

  logic [NS-1:0] vld_q, vld_d, adv;

  logic signed [LIN_W-1:0]  lin_d [NUM_WHEELS];
  logic signed [LIN_W-1:0]  lin_q [NUM_WHEELS];
  logic signed [LEV_W-1:0]  lev_d [NUM_WHEELS];
  logic signed [LEV_W-1:0]  lev_q [NUM_WHEELS];
  logic signed [12:0]       vw_d, vw_q;
  logic signed [TURN_W-1:0] pw_d [NUM_WHEELS];
  logic signed [TURN_W-1:0] pw_q [NUM_WHEELS];
  logic signed [LINC_W-1:0] lc_d [NUM_WHEELS];
  logic signed [LINC_W-1:0] lc_q [NUM_WHEELS];
  logic signed [NUM_W-1:0]  num_d [NUM_WHEELS];
  logic signed [NUM_W-1:0]  num_q [NUM_WHEELS];
  logic signed [PROD_W:0]   mul_full [NUM_WHEELS];
  logic signed [PROD_W-1:0] prod_d [NUM_WHEELS];
  logic signed [PROD_W-1:0] prod_q [NUM_WHEELS];

  logic signed [14:0]      vx_c, vy_c;
  logic signed [LIN_W-1:0] vx_e, vy_e;
  logic signed [10:0]      x_off, y_off;
  logic signed [LEV_W-1:0] s_e, x2, y2;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_q[k] || adv[k+1];
  end

  always_comb begin
    logic [NS-1:0] vld_in;
    vld_in = {vld_q[NS-2:0], in_valid_i};
    for (int k = 0; k < NS; k++) vld_d[k] = adv[k] ? vld_in[k] : vld_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    vx_c  = clamp_lin(speed_x_i, cfg_i.max_linear_speed);
    vy_c  = clamp_lin(speed_y_i, cfg_i.max_linear_speed);
    vw_d  = spin_mode_i ? turn_rate_i : clamp_turn(turn_rate_i, cfg_i.max_turn_rate);
    x_off = spin_mode_i ? cfg_i.spin_x_offset_mm : cfg_i.gimbal_x_offset_mm;
    y_off = spin_mode_i ? 11'sd0 : cfg_i.gimbal_y_offset_mm;
    vx_e  = 16'(vx_c);
    vy_e  = 16'(vy_c);
    s_e   = $signed({2'b00, cfg_i.span_sum_mm});
    x2    = $signed({{2{x_off[10]}}, x_off, 1'b0});
    y2    = $signed({{2{y_off[10]}}, y_off, 1'b0});

    lin_d[0] = -vx_e - vy_e;
    lin_d[1] = vx_e - vy_e;
    lin_d[2] = vx_e + vy_e;
    lin_d[3] = vy_e - vx_e;
    lev_d[0] = s_e - x2 + y2;
    lev_d[1] = s_e - x2 - y2;
    lev_d[2] = s_e + x2 - y2;
    lev_d[3] = s_e + x2 + y2;

    for (int i = 0; i < NUM_WHEELS; i++) begin
      pw_d[i]     = vw_q * lev_q[i];
      lc_d[i]     = lin_q[i] * DEG_X10_S;
      num_d[i]    = NUM_W'(lc_q[i]) - (NUM_W'(pw_q[i]) <<< 2) - NUM_W'(pw_q[i]);
      mul_full[i] = num_q[i] * $signed({1'b0, cfg_i.rpm_ratio_q20});
      prod_d[i]   = mul_full[i][PROD_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      lin_q <= lin_d;
      lev_q <= lev_d;
      vw_q  <= vw_d;
    end
    if (adv[1]) begin
      pw_q <= pw_d;
      lc_q <= lc_d;
    end
    if (adv[2]) begin
      num_q <= num_d;
    end
    if (adv[3]) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) prod_o[i] = prod_q[i];
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

endmodule

>>> design/mwsm_quot.sv
// Division of the rpm products by 573 * 2^20 with truncation toward zero and
// 16-bit saturation, by reciprocal multiply and one correction; uses mwsm_pkg.
module mwsm_quot (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  mwsm_pkg::prod_t [mwsm_pkg::NUM_WHEELS-1:0]  prod_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output mwsm_pkg::rpm_t [mwsm_pkg::NUM_WHEELS-1:0]   rpm_o
);
  import mwsm_pkg::*;

  localparam int NS = 3;

  logic [NS-1:0] vld_q, vld_d, adv;

  logic [PROD_W-1:0]          mag [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]      neg0_d, neg0_q, neg1_q;
  logic [MAG_W-1:0]           n0_d [NUM_WHEELS];
  logic [MAG_W-1:0]           n0_q [NUM_WHEELS];
  logic [MAG_W-1:0]           n1_q [NUM_WHEELS];
  logic [MAG_W+RECIP_W-1:0]   t_full [NUM_WHEELS];
  logic [QUOT_W-1:0]          q0_d [NUM_WHEELS];
  logic [QUOT_W-1:0]          q0_q [NUM_WHEELS];
  logic [MAG_W-1:0]           qm [NUM_WHEELS];
  logic [MAG_W-1:0]           rem [NUM_WHEELS];
  logic [QUOT_W-1:0]          qc [NUM_WHEELS];
  rpm_t                       w_d [NUM_WHEELS];
  rpm_t                       w_q [NUM_WHEELS];

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_q[k] || adv[k+1];
  end

  always_comb begin
    logic [NS-1:0] vld_in;
    vld_in = {vld_q[NS-2:0], in_valid_i};
    for (int k = 0; k < NS; k++) vld_d[k] = adv[k] ? vld_in[k] : vld_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      neg0_d[i] = prod_i[i][PROD_W-1];
      mag[i]    = neg0_d[i] ? (~prod_i[i] + 1'b1) : prod_i[i];
      n0_d[i]   = mag[i][Q_FRAC+MAG_W-1:Q_FRAC];

      t_full[i] = n0_q[i] * RECIP_M;
      q0_d[i]   = t_full[i][MAG_W+RECIP_W-1:RECIP_SHIFT];

      // The reciprocal estimate is at most one below the true quotient.
      qm[i]  = q0_q[i] * MAG_W'(DEG_X10);
      rem[i] = n1_q[i] - qm[i];
      qc[i]  = q0_q[i] + QUOT_W'(rem[i] >= MAG_W'(DEG_X10));
      if (neg1_q[i]) begin
        w_d[i] = (qc[i] > QUOT_W'(RPM_NEG_LIM)) ? RPM_MIN : -qc[i][RPM_W-1:0];
      end else begin
        w_d[i] = (qc[i] > QUOT_W'(RPM_POS_LIM)) ? RPM_MAX : qc[i][RPM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      neg0_q <= neg0_d;
      n0_q   <= n0_d;
    end
    if (adv[1]) begin
      neg1_q <= neg0_q;
      n1_q   <= n0_q;
      q0_q   <= q0_d;
    end
    if (adv[2]) begin
      w_q <= w_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) rpm_o[i] = w_q[i];
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

endmodule

>>> design/mwsm_scale.sv
// Wheel limit scaling: largest magnitude, limit compare and a pipelined
// restoring divider for w * limit / max, plus the output register; uses mwsm_pkg.
module mwsm_scale (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [mwsm_pkg::LIM_W-1:0]                 wheel_rpm_limit_i,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  mwsm_pkg::rpm_t [mwsm_pkg::NUM_WHEELS-1:0]  rpm_i,
  output logic                                       out_valid_o,
  input  logic                                       out_ready_i,
  output mwsm_pkg::rpm_t [mwsm_pkg::NUM_WHEELS-1:0]  rpm_o,
  output logic                                       scaled_o
);
  import mwsm_pkg::*;

  localparam int NS    = DIV_STAGES + 3;
  localparam int DNUM_W = RPM_W + LIM_W;

  typedef struct packed {
    logic [NUM_WHEELS-1:0][RPM_W-1:0]   w;
    logic [NUM_WHEELS-1:0][RPM_W-1:0]   rem;
    logic [NUM_WHEELS-1:0][DIV_Q_W-1:0] lo;
    logic [RPM_W-1:0]                   mx;
    logic                               scaled;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s);
    div_st_t      o;
    logic [RPM_W:0] t;
    o = s;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {o.rem[i], o.lo[i][DIV_Q_W-1]};
        if (t >= {1'b0, o.mx}) begin
          o.rem[i] = RPM_W'(t - {1'b0, o.mx});
          o.lo[i]  = {o.lo[i][DIV_Q_W-2:0], 1'b1};
        end else begin
          o.rem[i] = t[RPM_W-1:0];
          o.lo[i]  = {o.lo[i][DIV_Q_W-2:0], 1'b0};
        end
      end
    end
    return o;
  endfunction

  logic [NS-1:0] vld_q, vld_d, adv;

  logic [RPM_W-1:0]  abs_d [NUM_WHEELS];
  logic [RPM_W-1:0]  abs_q [NUM_WHEELS];
  logic [RPM_W-1:0]  w0_q [NUM_WHEELS];
  logic [RPM_W-1:0]  mx01, mx23, mx_d, mx_q;
  logic [DNUM_W-1:0] dnum [NUM_WHEELS];
  div_st_t           st_d [DIV_STAGES+1];
  div_st_t           st_q [DIV_STAGES+1];
  rpm_t              rpm_d [NUM_WHEELS];
  rpm_t              rpm_q [NUM_WHEELS];
  logic              scaled_d, scaled_q;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) adv[k] = !vld_q[k] || adv[k+1];
  end

  always_comb begin
    logic [NS-1:0] vld_in;
    vld_in = {vld_q[NS-2:0], in_valid_i};
    for (int k = 0; k < NS; k++) vld_d[k] = adv[k] ? vld_in[k] : vld_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      abs_d[i] = rpm_i[i][RPM_W-1] ? (~rpm_i[i] + 1'b1) : rpm_i[i];
    end
    mx01 = (abs_d[0] > abs_d[1]) ? abs_d[0] : abs_d[1];
    mx23 = (abs_d[2] > abs_d[3]) ? abs_d[2] : abs_d[3];
    mx_d = (mx01 > mx23) ? mx01 : mx23;

    // Quotient stays below 2^15 because no magnitude exceeds the maximum.
    for (int i = 0; i < NUM_WHEELS; i++) begin
      dnum[i]         = abs_q[i] * wheel_rpm_limit_i;
      st_d[0].w[i]    = w0_q[i];
      st_d[0].rem[i]  = dnum[i][DNUM_W-1:DIV_Q_W];
      st_d[0].lo[i]   = dnum[i][DIV_Q_W-1:0];
    end
    st_d[0].mx     = mx_q;
    st_d[0].scaled = mx_q > {1'b0, wheel_rpm_limit_i};

    for (int k = 1; k <= DIV_STAGES; k++) st_d[k] = div_step(st_q[k-1]);

    scaled_d = st_q[DIV_STAGES].scaled;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (!scaled_d) begin
        rpm_d[i] = st_q[DIV_STAGES].w[i];
      end else if (st_q[DIV_STAGES].w[i][RPM_W-1]) begin
        rpm_d[i] = -RPM_W'(st_q[DIV_STAGES].lo[i]);
      end else begin
        rpm_d[i] = RPM_W'(st_q[DIV_STAGES].lo[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      abs_q <= abs_d;
      mx_q  <= mx_d;
      for (int i = 0; i < NUM_WHEELS; i++) w0_q[i] <= rpm_i[i];
    end
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (adv[k+1]) st_q[k] <= st_d[k];
    end
    if (adv[NS-1]) begin
      rpm_q    <= rpm_d;
      scaled_q <= scaled_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) rpm_o[i] = rpm_q[i];
  end

  assign scaled_o    = scaled_q;
  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NS-1];

endmodule
